### src/utf8_to_utf16_transcoder_macros.svh
// utf8_to_utf16_transcoder_macros.svh: assertion macros for the transcoder
// no dependencies; taken in by the modules that carry assertions
`ifndef UTF8_TO_UTF16_TRANSCODER_MACROS_SVH
`define UTF8_TO_UTF16_TRANSCODER_MACROS_SVH

// check a property at every rising edge outside reset
`define U8U16_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property at every rising edge, reset included
`define U8U16_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/u8u16_pkg.sv
// u8u16_pkg: shared types and constants of the utf-8 to utf-16 transcoder
// no dependencies; used by the front, queue, back and top level
package u8u16_pkg;

  localparam logic [15:0] REPLACEMENT_UNIT   = 16'hFFFD;
  localparam logic [20:0] MAX_CODE_POINT     = 21'h10FFFF;
  localparam logic [20:0] SURROGATE_LOW      = 21'h00D800;
  localparam logic [20:0] SURROGATE_HIGH     = 21'h00DFFF;
  localparam logic [15:0] HIGH_SURR_BASE     = 16'hD800;
  localparam logic [15:0] LOW_SURR_BASE      = 16'hDC00;
  localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h010000;
  localparam logic [20:0] MIN_THREE_BYTE     = 21'h000800;
  localparam logic [20:0] MIN_TWO_BYTE       = 21'h000080;

  // one classified byte: rep replacement units first, then ntail units
  typedef struct packed {
    logic [2:0]  rep;
    logic [1:0]  ntail;
    logic [15:0] tail0;
    logic [15:0] tail1;
    logic        eos;
  } u8u16_job_t;

endpackage

### src/u8u16_front.sv
// u8u16_front: accepts utf-8 bytes, tracks the open sequence, builds jobs
// depends on u8u16_pkg
module u8u16_front
  import u8u16_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       end_of_string,
  output logic       push,
  output u8u16_job_t job
);

  logic [20:0] partial;
  logic [20:0] partial_next;
  logic [2:0]  seq_len;
  logic [2:0]  seq_len_next;
  logic [2:0]  received;
  logic [2:0]  received_next;

  logic [20:0] cp_ext;
  logic [20:0] cp_min;
  logic [20:0] sup;
  logic [2:0]  received_inc;
  logic        is_cont;
  logic        is_open;
  logic        value_ok;

  // shared datapath for the continuation case
  always_comb begin
    is_cont      = (data_byte[7:6] == 2'b10);
    is_open      = (seq_len != 3'd0);
    cp_ext       = {partial[14:0], data_byte[5:0]};
    received_inc = received + 3'd1;
    sup          = cp_ext - SUPPLEMENTARY_BASE;
    case (seq_len)
      3'd2:    cp_min = MIN_TWO_BYTE;
      3'd3:    cp_min = MIN_THREE_BYTE;
      default: cp_min = SUPPLEMENTARY_BASE;
    endcase
    value_ok = (cp_ext >= cp_min) && (cp_ext <= MAX_CODE_POINT) &&
               !((cp_ext >= SURROGATE_LOW) && (cp_ext <= SURROGATE_HIGH));
  end

  // classify the byte and work out the next sequence state
  always_comb begin
    job.rep       = 3'd0;
    job.ntail     = 2'd0;
    job.tail0     = 16'h0000;
    job.tail1     = 16'h0000;
    job.eos       = end_of_string;
    partial_next  = partial;
    seq_len_next  = seq_len;
    received_next = received;

    if (is_open && is_cont) begin
      partial_next  = cp_ext;
      received_next = received_inc;
      if (received_inc == seq_len) begin
        partial_next  = 21'd0;
        seq_len_next  = 3'd0;
        received_next = 3'd0;
        if (!value_ok) begin
          job.rep = seq_len;
        end else if (cp_ext[20:16] == 5'd0) begin
          job.ntail = 2'd1;
          job.tail0 = cp_ext[15:0];
        end else begin
          job.ntail = 2'd2;
          job.tail0 = HIGH_SURR_BASE + {6'd0, sup[19:10]};
          job.tail1 = LOW_SURR_BASE + {6'd0, sup[9:0]};
        end
      end
    end else begin
      // broken sequence flushes its bytes, then the byte is a fresh lead
      if (is_open) begin
        job.rep = received;
      end
      partial_next  = 21'd0;
      seq_len_next  = 3'd0;
      received_next = 3'd0;
      if (!data_byte[7]) begin
        job.ntail = 2'd1;
        job.tail0 = {8'h00, data_byte};
      end else if (data_byte[7:5] == 3'b110) begin
        partial_next  = {16'd0, data_byte[4:0]};
        seq_len_next  = 3'd2;
        received_next = 3'd1;
      end else if (data_byte[7:4] == 4'b1110) begin
        partial_next  = {17'd0, data_byte[3:0]};
        seq_len_next  = 3'd3;
        received_next = 3'd1;
      end else if (data_byte[7:3] == 5'b11110) begin
        partial_next  = {18'd0, data_byte[2:0]};
        seq_len_next  = 3'd4;
        received_next = 3'd1;
      end else begin
        job.ntail = 2'd1;
        job.tail0 = REPLACEMENT_UNIT;
      end
    end

    // sequence cut off at string end
    if (end_of_string && (seq_len_next != 3'd0)) begin
      job.rep       = job.rep + received_next;
      partial_next  = 21'd0;
      seq_len_next  = 3'd0;
      received_next = 3'd0;
    end

    push = accept && ((job.rep != 3'd0) || (job.ntail != 2'd0));
  end

  // sequence state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      partial  <= 21'd0;
      seq_len  <= 3'd0;
      received <= 3'd0;
    end else if (accept) begin
      partial  <= partial_next;
      seq_len  <= seq_len_next;
      received <= received_next;
    end
  end

endmodule

### src/u8u16_queue.sv
// u8u16_queue: short fifo of jobs between the front and the back
// depends on u8u16_pkg and utf8_to_utf16_transcoder_macros.svh
`include "utf8_to_utf16_transcoder_macros.svh"

module u8u16_queue
  import u8u16_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  u8u16_job_t push_job,
  output logic       full,
  input  logic       pop,
  output u8u16_job_t head_job,
  output logic       empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  u8u16_job_t    slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == CW'(0));
  assign head_job = slots[rd_ptr];

  // job storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  // checks on fill level and job contents
  `U8U16_ASSERT(a_no_overfill, clk, rst, (count <= CW'(DEPTH)), "queue over its depth")
  `U8U16_ASSERT(a_no_push_full, clk, rst, (push |-> !full), "job written into full queue")
  `U8U16_ASSERT(a_no_pop_empty, clk, rst, (pop |-> !empty), "job taken from empty queue")
  `U8U16_ASSERT(a_job_nonempty, clk, rst, (push |-> ((push_job.rep != 3'd0) || (push_job.ntail != 2'd0))), "job with no units")
  `U8U16_ASSERT(a_count_up, clk, rst, ((push && !pop) |=> (count == $past(count) + CW'(1))), "fill count missed a write")

endmodule

### src/u8u16_back.sv
// u8u16_back: expands the job at the queue head into utf-16 words
// depends on u8u16_pkg
module u8u16_back
  import u8u16_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  u8u16_job_t head_job,
  input  logic       empty,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [15:0] code_unit,
  output logic       run_last,
  output logic       string_last
);

  logic [1:0] idx;
  logic [2:0] idx_ext;
  logic [2:0] total;

  // word select within the current job
  always_comb begin
    idx_ext   = {1'b0, idx};
    total     = head_job.rep + {1'b0, head_job.ntail};
    out_valid = !empty;
    if (idx_ext < head_job.rep) begin
      code_unit = REPLACEMENT_UNIT;
    end else if (idx_ext == head_job.rep) begin
      code_unit = head_job.tail0;
    end else begin
      code_unit = head_job.tail1;
    end
    run_last    = (idx_ext == total - 3'd1);
    string_last = run_last && head_job.eos;
    pop         = out_valid && out_ready && run_last;
  end

  // word counter
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (out_valid && out_ready) begin
      idx <= run_last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

### src/utf8_to_utf16_transcoder.sv
// utf8_to_utf16_transcoder: top level of the utf-8 to utf-16 transcoder
// depends on u8u16_pkg, u8u16_front, u8u16_queue and u8u16_back
//
// Usage:
//  - slave side takes one utf-8 byte per word; s_tlast marks the final byte
//    of a string
//  - master side gives utf-16 code units; m_tuser is high on the last word
//    caused by one byte, m_tlast on the last word of the whole string
//  - a byte gives zero to four words: plain or completed characters give
//    one (two for a surrogate pair), bad input gives U+FFFD per byte
//  - the job of a byte is written into the job queue; its first word is
//    offered once that job reaches the queue head
//  - throughput: one byte per cycle while each byte yields at most one word
//    and m_tready is high; the back end sends one word per cycle while
//    m_tready is high; the job queue of QUEUE_DEPTH entries absorbs bursts
//  - s_tready drops only when the job queue is full
//  - when the receiver stalls, the current word holds and further bytes
//    fill the queue, then the slave side stalls
//  - reset (synchronous, rst high) closes any open sequence and empties
//    the queue
module utf8_to_utf16_transcoder
  import u8u16_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // end_of_string
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] code_unit
  output logic        m_tuser,   // run_last
  output logic        m_tlast    // string_last
);

  logic       full;
  logic       empty;
  logic       push;
  logic       pop;
  u8u16_job_t push_job;
  u8u16_job_t head_job;

  assign s_tready = !full;

  // byte classification
  u8u16_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (s_tvalid && s_tready),
    .data_byte     (s_tdata),
    .end_of_string (s_tlast),
    .push          (push),
    .job           (push_job)
  );

  // job queue
  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head_job (head_job),
    .empty    (empty)
  );

  // word output
  u8u16_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_job    (head_job),
    .empty       (empty),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .code_unit   (m_tdata),
    .run_last    (m_tuser),
    .string_last (m_tlast)
  );

endmodule
